// ===== design/pic_pkg.sv =====
// Shared types and constants for the clamped PI regulator.
// Used by every module of the block; no dependencies of its own.
package pic_pkg;

  // Input actions.
  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_SET_SP = 2'd1,
    ACT_START  = 2'd2,
    ACT_STOP   = 2'd3
  } action_e;

  // Configuration register indexes.
  localparam logic [1:0] CFG_P_GAIN    = 2'd0;
  localparam logic [1:0] CFG_I_GAIN    = 2'd1;
  localparam logic [1:0] CFG_INTEG_MAX = 2'd2;
  localparam logic [1:0] CFG_INTEG_MIN = 2'd3;

  localparam int CfgDataW = 32;
  localparam int SumW     = 50;

  // Reset values of the configuration registers.
  localparam logic [15:0]        PGainRst    = 16'd256;
  localparam logic [15:0]        IGainRst    = 16'd0;
  localparam logic signed [31:0] IntegMaxRst = 32'sd25600;
  localparam logic signed [31:0] IntegMinRst = 32'sd0;

  // Full scale (100 percent) in Q.16 of the sum and Q7.8 of the drive.
  localparam logic signed [SumW-1:0] DriveFullQ16 = 50'sd6553600;
  localparam logic [14:0]            DriveFullQ8  = 15'd25600;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [23:0] value;
  } in_beat_t;

  typedef struct packed {
    logic [14:0] drive;
    logic        clamped;
  } out_beat_t;

  typedef struct packed {
    logic [15:0]        p_gain;
    logic [15:0]        i_gain;
    logic signed [31:0] integ_max;
    logic signed [31:0] integ_min;
  } cfg_t;

  // Error and clamped integrator of one update.
  typedef struct packed {
    logic               zero;
    logic signed [24:0] err;
    logic signed [31:0] integ;
  } s1_t;

  // Registered products of one update.
  typedef struct packed {
    logic               zero;
    logic signed [41:0] p_prod;
    logic signed [48:0] i_prod;
  } s2_t;

endpackage

// ===== design/pic_update.sv =====
// Regulator state stage: setpoint, running flag and clamped integrator.
// Depends on pic_pkg for the beat and stage types.
module pic_update
  import pic_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  input  in_beat_t beat_i,
  output logic     ready_o,
  input  cfg_t     cfg_i,
  output logic     valid_o,
  output s1_t      s1_o,
  input  logic     ready_i
);

  logic               v1_q, v1_d;
  s1_t                s1_q, s1_d;
  logic signed [31:0] integ_q, integ_d;
  logic signed [23:0] sp_q, sp_d;
  logic               run_q, run_d;
  logic               take;
  logic signed [24:0] err;
  logic signed [31:0] base;
  logic signed [32:0] acc;
  logic signed [31:0] clamp;

  assign ready_o = !v1_q || ready_i;
  assign take    = valid_i && ready_o;

  // Error, integrator sum and clamp in the fixed order: upper limit first.
  always_comb begin
    err  = {sp_q[23], sp_q} - {beat_i.value[23], beat_i.value};
    base = (beat_i.action == ACT_START) ? 32'sd0 : integ_q;
    acc  = {base[31], base} + {{8{err[24]}}, err};
    if (acc >= $signed({cfg_i.integ_max[31], cfg_i.integ_max})) begin
      clamp = cfg_i.integ_max;
    end else if (acc <= $signed({cfg_i.integ_min[31], cfg_i.integ_min})) begin
      clamp = cfg_i.integ_min;
    end else begin
      clamp = acc[31:0];
    end
  end

  // Action decode and next state.
  always_comb begin
    integ_d  = integ_q;
    sp_d     = sp_q;
    run_d    = run_q;
    s1_d     = s1_q;
    v1_d     = v1_q && !ready_i;
    if (take) begin
      unique case (beat_i.action)
        ACT_TICK: begin
          if (run_q) begin
            integ_d = clamp;
            s1_d    = '{zero: 1'b0, err: err, integ: clamp};
            v1_d    = 1'b1;
          end
        end
        ACT_SET_SP: begin
          if (sp_q > beat_i.value) begin
            integ_d = 32'sd0;
          end
          sp_d = beat_i.value;
        end
        ACT_START: begin
          integ_d = clamp;
          run_d   = 1'b1;
          s1_d    = '{zero: 1'b0, err: err, integ: clamp};
          v1_d    = 1'b1;
        end
        default: begin
          run_d = 1'b0;
          s1_d  = '{zero: 1'b1, err: '0, integ: '0};
          v1_d  = 1'b1;
        end
      endcase
    end
  end

  // State and stage registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      integ_q <= '0;
      sp_q    <= '0;
      run_q   <= 1'b0;
    end else begin
      v1_q    <= v1_d;
      integ_q <= integ_d;
      sp_q    <= sp_d;
      run_q   <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
  end

  assign valid_o = v1_q;
  assign s1_o    = s1_q;

endmodule

// ===== design/pic_mult.sv =====
// Product stage: P gain times error and I gain times integrator.
// Depends on pic_pkg for the stage and configuration types.
module pic_mult
  import pic_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  s1_t  s1_i,
  output logic ready_o,
  input  cfg_t cfg_i,
  output logic valid_o,
  output s2_t  s2_o,
  input  logic ready_i
);

  logic v2_q;
  s2_t  s2_q;
  logic take;

  assign ready_o = !v2_q || ready_i;
  assign take    = valid_i && ready_o;

  // Stage valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (ready_o) begin
      v2_q <= valid_i;
    end
  end

  // Both products are exact; gains are unsigned, so they get a zero sign bit.
  always_ff @(posedge clk_i) begin
    if (take) begin
      s2_q.zero   <= s1_i.zero;
      s2_q.p_prod <= 42'(s1_i.err) * 42'($signed({1'b0, cfg_i.p_gain}));
      s2_q.i_prod <= 49'($signed({1'b0, cfg_i.i_gain})) * 49'(s1_i.integ);
    end
  end

  assign valid_o = v2_q;
  assign s2_o    = s2_q;

endmodule

// ===== design/pic_sat.sv =====
// Output stage: sums the products and saturates the drive to 0..100 percent.
// Depends on pic_pkg for the stage and result types.
module pic_sat
  import pic_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  s2_t       s2_i,
  output logic      ready_o,
  output logic      valid_o,
  output out_beat_t beat_o,
  input  logic      ready_i
);

  logic                 out_valid_q;
  out_beat_t            out_q, out_d;
  logic signed [SumW-1:0] sum;

  assign ready_o = !out_valid_q || ready_i;

  // Sum and saturation; a stop beat forces a zero drive.
  always_comb begin
    sum = {{(SumW-42){s2_i.p_prod[41]}}, s2_i.p_prod}
        + {{(SumW-49){s2_i.i_prod[48]}}, s2_i.i_prod};
    if (s2_i.zero) begin
      out_d = '{drive: '0, clamped: 1'b0};
    end else if (sum > DriveFullQ16) begin
      out_d = '{drive: DriveFullQ8, clamped: 1'b1};
    end else if (sum < 0) begin
      out_d = '{drive: '0, clamped: 1'b1};
    end else begin
      out_d = '{drive: sum[22:8], clamped: 1'b0};
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ready_o) begin
      out_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      out_q <= out_d;
    end
  end

  assign valid_o = out_valid_q;
  assign beat_o  = out_q;

endmodule

// ===== design/pi_controller_clamped.sv =====
// Clamped PI regulator, top level: input register, configuration and stages.
// A result beat passes the input register, state stage, product stage and
// result register in that order; the block takes one beat a cycle while the
// result side does not stall.
// Ticks while stopped and setpoint writes give no result beat.
// Reset (rst_ni, asynchronous) empties the pipe, stops the regulator, clears
// setpoint and integrator, and loads the configuration reset values.
module pi_controller_clamped
  import pic_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_beat_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_beat_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t     cfg_q;
  logic     v0_q;
  in_beat_t in_q;
  logic     ready0, ready1, ready2;
  logic     v1, v2;
  s1_t      s1;
  s2_t      s2;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{p_gain: PGainRst, i_gain: IGainRst,
                 integ_max: IntegMaxRst, integ_min: IntegMinRst};
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_P_GAIN:    cfg_q.p_gain    <= cfg_data_i[15:0];
        CFG_I_GAIN:    cfg_q.i_gain    <= cfg_data_i[15:0];
        CFG_INTEG_MAX: cfg_q.integ_max <= $signed(cfg_data_i);
        default:       cfg_q.integ_min <= $signed(cfg_data_i);
      endcase
    end
  end

  // Input register.
  assign in_ready_o = !v0_q || ready0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (in_ready_o) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  pic_update u_update (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v0_q),
    .beat_i  (in_q),
    .ready_o (ready0),
    .cfg_i   (cfg_q),
    .valid_o (v1),
    .s1_o    (s1),
    .ready_i (ready1)
  );

  pic_mult u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1),
    .s1_i    (s1),
    .ready_o (ready1),
    .cfg_i   (cfg_q),
    .valid_o (v2),
    .s2_o    (s2),
    .ready_i (ready2)
  );

  pic_sat u_sat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2),
    .s2_i    (s2),
    .ready_o (ready2),
    .valid_o (out_valid_o),
    .beat_o  (out_data_o),
    .ready_i (out_ready_i)
  );

  // The drive never leaves 0..100 percent.
  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.drive <= DriveFullQ8)
    else $error("drive above full scale");

  // A saturated result sits exactly at one of the two rails.
  a_clamp_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.clamped |->
      out_data_o.drive == '0 || out_data_o.drive == DriveFullQ8)
    else $error("clamped flag off the rails");

  // A new result beat only comes from a filled product stage.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(v2))
    else $error("result beat without product stage");

endmodule

// ===== tb/sv/pic_drive_checker.sv =====
// Drive checker for the clamped PI regulator: watches both channels and the
// configuration port, predicts each result beat and compares it field by field.
// Depends on pic_pkg for the beat, action and configuration types.
module pic_drive_checker
  import pic_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  in_beat_t            in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  out_beat_t           out_data_i,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  pending_o,
  output int                  errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the regulator state and its registers.
  cfg_t               cfg_q;
  logic signed [31:0] integ_q;
  logic signed [23:0] setpoint_q;
  logic               running_q;

  // Drives still owed by the block, oldest first.
  out_beat_t expected_drive_q[$];

  // One regulator update: integrate the error, clamp, then weight and saturate.
  function automatic out_beat_t update_drive(logic signed [23:0] pv);
    longint    err;
    longint    acc;
    longint    sum;
    out_beat_t r;
    err = longint'(setpoint_q) - longint'(pv);
    acc = longint'(integ_q) + err;
    // The upper limit is tested first, so it wins where both limits apply.
    if (acc >= longint'(cfg_q.integ_max)) begin
      acc = longint'(cfg_q.integ_max);
    end else if (acc <= longint'(cfg_q.integ_min)) begin
      acc = longint'(cfg_q.integ_min);
    end
    integ_q = acc[31:0];
    sum = err * longint'(cfg_q.p_gain) + longint'(cfg_q.i_gain) * longint'(integ_q);
    // Exactly full scale passes through without the clamped flag.
    if (sum > longint'(DriveFullQ16)) begin
      r.drive   = DriveFullQ8;
      r.clamped = 1'b1;
    end else if (sum < 0) begin
      r.drive   = '0;
      r.clamped = 1'b1;
    end else begin
      r.drive   = 15'(sum >>> 8);
      r.clamped = 1'b0;
    end
    return r;
  endfunction

  // Applies one input beat to the shadow state; returns 1 when it owes a drive.
  function automatic bit predict_beat(in_beat_t b, output out_beat_t r);
    bit has_drive;
    r         = '0;
    has_drive = 1'b1;
    case (action_e'(b.action))
      ACT_TICK: begin
        if (running_q) begin
          r = update_drive(b.value);
        end else begin
          has_drive = 1'b0;
        end
      end
      ACT_SET_SP: begin
        // Lowering the setpoint throws away the accumulated integral.
        if (setpoint_q > $signed(b.value)) begin
          integ_q = '0;
        end
        setpoint_q = b.value;
        has_drive  = 1'b0;
      end
      ACT_START: begin
        integ_q   = '0;
        running_q = 1'b1;
        r         = update_drive(b.value);
      end
      default: begin
        running_q = 1'b0;
      end
    endcase
    return has_drive;
  endfunction

  // Track the registers, compare result beats and queue new predictions.
  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t want;
    if (!rst_ni) begin
      cfg_q.p_gain    = PGainRst;
      cfg_q.i_gain    = IGainRst;
      cfg_q.integ_max = IntegMaxRst;
      cfg_q.integ_min = IntegMinRst;
      integ_q         = '0;
      setpoint_q      = '0;
      running_q       = 1'b0;
      expected_drive_q.delete();
      pending_o       = 0;
      errors_o        = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_P_GAIN:    cfg_q.p_gain    = cfg_data_i[15:0];
          CFG_I_GAIN:    cfg_q.i_gain    = cfg_data_i[15:0];
          CFG_INTEG_MAX: cfg_q.integ_max = cfg_data_i;
          CFG_INTEG_MIN: cfg_q.integ_min = cfg_data_i;
          default: ;
        endcase
      end

      if (out_valid_i && out_ready_i) begin
        if (expected_drive_q.size() == 0) begin
          $error("unexpected result beat: drive %0d clamped %0d",
                 out_data_i.drive, out_data_i.clamped);
          errors_o = errors_o + 1;
        end else begin
          want = expected_drive_q.pop_front();
          if (out_data_i.drive !== want.drive) begin
            $error("drive mismatch: expected %0d, actual %0d",
                   want.drive, out_data_i.drive);
            errors_o = errors_o + 1;
          end
          if (out_data_i.clamped !== want.clamped) begin
            $error("clamped mismatch: expected %0d, actual %0d",
                   want.clamped, out_data_i.clamped);
            errors_o = errors_o + 1;
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        if (predict_beat(in_data_i, want)) begin
          expected_drive_q.push_back(want);
        end
      end
      pending_o = expected_drive_q.size();
    end
  end

endmodule

// ===== tb/sv/tb_pi_controller_clamped.sv =====
// Top of the clamped PI regulator testbench: clock, reset, stimulus and verdict.
// Depends on pic_pkg, the pi_controller_clamped block and pic_drive_checker.
module tb_pi_controller_clamped;
  timeunit 1ns;
  timeprecision 1ps;
  import pic_pkg::*;

  localparam int ClkPeriod     = 10;
  localparam int SettleCycles  = 8;
  localparam int WatchdogLimit = 2000;
  localparam int PhaseBeats    = 200;
  localparam int NumPhases     = 7;

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_beat_t            in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_beat_t           out_data;
  logic                cfg_we    = 1'b0;
  logic [1:0]          cfg_index = CFG_P_GAIN;
  logic [CfgDataW-1:0] cfg_data  = '0;

  int                  pending;
  int                  errors;
  int unsigned         quiet_cycles = 0;
  bit                  calm = 1'b0;

  // What the stimulus believes about the regulator, used to aim process values.
  logic signed [23:0]  sp_shadow = '0;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  pi_controller_clamped DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  pic_drive_checker drive_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  // Result side stalls now and then, except during a calm phase.
  always @(negedge clk_i) begin
    out_ready <= calm || ($urandom_range(99) >= 7);
  end

  // Watchdog on cycles where no beat and no register write goes through.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WatchdogLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one input beat, with a random gap before it outside a calm phase, and wait until taken.
  task automatic send_beat(action_e act, logic signed [23:0] val);
    in_beat_t b;
    b.action = act;
    b.value  = val;
    while (!calm && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
  endtask

  // Let every owed drive come back, then give the pipe time to go quiet.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Write all four registers on back-to-back cycles; upper bits of the gain writes carry junk.
  task automatic load_cfg(cfg_t c);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_P_GAIN;
    cfg_data  <= {16'($urandom), c.p_gain};
    @(negedge clk_i);
    cfg_index <= CFG_I_GAIN;
    cfg_data  <= {16'($urandom), c.i_gain};
    @(negedge clk_i);
    cfg_index <= CFG_INTEG_MAX;
    cfg_data  <= c.integ_max;
    @(negedge clk_i);
    cfg_index <= CFG_INTEG_MIN;
    cfg_data  <= c.integ_min;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // Random register setting, biased toward extremes and inverted limits.
  function automatic cfg_t pick_cfg();
    cfg_t c;
    case ($urandom_range(3))
      0:       c.p_gain = '0;
      1:       c.p_gain = 16'hFFFF;
      2:       c.p_gain = 16'($urandom_range(1024));
      default: c.p_gain = 16'($urandom);
    endcase
    case ($urandom_range(3))
      0:       c.i_gain = '0;
      1:       c.i_gain = 16'hFFFF;
      2:       c.i_gain = 16'($urandom_range(64));
      default: c.i_gain = 16'($urandom);
    endcase
    case ($urandom_range(3))
      0: begin
        c.integ_max = 32'($urandom_range(200000));
        c.integ_min = 32'(-int'($urandom_range(200000)));
      end
      1: begin
        c.integ_max = 32'sh7FFF_FFFF;
        c.integ_min = 32'sh8000_0000;
      end
      2: begin
        c.integ_max = 32'(-int'($urandom_range(5000)));
        c.integ_min = 32'($urandom_range(5000, 1));
      end
      default: begin
        c.integ_max = $urandom;
        c.integ_min = $urandom;
      end
    endcase
    return c;
  endfunction

  initial begin
    cfg_t               c;
    action_e            act;
    logic signed [23:0] val;
    int                 done;
    int                 off;

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part on the reset register values.
    send_beat(ACT_TICK,   24'sd0);         // tick while stopped: ignored
    send_beat(ACT_STOP,   24'sd0);         // stop while already stopped
    send_beat(ACT_SET_SP, 24'sd25600);     // setpoint 100.0
    send_beat(ACT_START,  24'sd0);         // sum lands exactly on full scale
    send_beat(ACT_TICK,   -24'sd1);        // just above full scale
    send_beat(ACT_TICK,   24'sd25600);     // zero error
    send_beat(ACT_TICK,   24'sd25601);     // just below zero
    send_beat(ACT_TICK,   24'sh800000);    // most negative process value
    send_beat(ACT_TICK,   24'sh7FFFFF);    // most positive process value
    send_beat(ACT_SET_SP, 24'sh7FFFFF);    // raise: integrator kept
    send_beat(ACT_TICK,   24'sh800000);    // largest positive error
    send_beat(ACT_SET_SP, 24'sh800000);    // lower: integrator cleared
    send_beat(ACT_TICK,   24'sh7FFFFF);    // largest negative error
    send_beat(ACT_SET_SP, 24'sd256);
    send_beat(ACT_START,  24'sd128);       // start while running
    send_beat(ACT_TICK,   24'sd128);
    send_beat(ACT_STOP,   24'sd0);
    send_beat(ACT_STOP,   24'sh5A5A5A);
    send_beat(ACT_TICK,   24'sd5);         // ignored again
    send_beat(ACT_SET_SP, 24'sd512);       // setpoint change while stopped
    send_beat(ACT_START,  24'shA5A5A5);
    send_beat(ACT_TICK,   24'sd100);
    send_beat(ACT_STOP,   24'sd0);
    sp_shadow = 24'sd512;

    // Random phases, each on its own register setting.
    for (int ph = 0; ph < NumPhases; ph++) begin
      drain();
      case (ph)
        0: begin
          c.p_gain    = 16'hFFFF;
          c.i_gain    = 16'hFFFF;
          c.integ_max = 32'sh7FFF_FFFF;
          c.integ_min = 32'sh8000_0000;
        end
        1: begin
          c.p_gain    = '0;
          c.i_gain    = 16'hFFFF;
          c.integ_max = 32'sh8000_0000;
          c.integ_min = 32'sh7FFF_FFFF;
        end
        default: c = pick_cfg();
      endcase
      load_cfg(c);
      calm <= (ph == 3);
      done = 0;
      while (done < PhaseBeats) begin
        case ($urandom_range(99)) inside
          [0:71]:  act = ACT_TICK;
          [72:84]: act = ACT_SET_SP;
          [85:94]: act = ACT_START;
          default: act = ACT_STOP;
        endcase
        // Mostly process values close to the setpoint, some anywhere.
        case ($urandom_range(9))
          6, 7: val = 24'($urandom);
          8:    val = $urandom_range(1) ? 24'sh800000 : 24'sh7FFFFF;
          9: begin
            off = int'($urandom_range(128)) - 64;
            val = 24'(sp_shadow + off);
          end
          default: begin
            off = int'($urandom_range(4096)) - 2048;
            val = 24'(sp_shadow + off);
          end
        endcase
        if (act == ACT_SET_SP) sp_shadow = val;
        done++;
        send_beat(act, val);
      end
    end

    drain();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
